FILE: rtl/pp_upd_pkg.sv
// Shared types and constants for the particle pool update core.
`default_nettype none
package pp_upd_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned LifeW = 16;
  localparam int unsigned ProgW = 17;

  localparam logic [ProgW-1:0] PROG_MAX = 17'd131071;
  localparam logic [ProgW-1:0] ONE_Q16  = 17'd65536;

  // Command codes of an input item.
  localparam logic CMD_EMIT = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FORCE_X    = 2'd0;
  localparam logic [1:0] REG_FORCE_Y    = 2'd1;
  localparam logic [1:0] REG_FRICTION   = 2'd2;
  localparam logic [1:0] REG_FADE_START = 2'd3;

  typedef struct packed {
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [PosW-1:0]  vel_x;
    logic [PosW-1:0]  vel_y;
    logic [31:0]      color;
    logic [LifeW-1:0] life;
    logic [ProgW-1:0] progress;
  } slot_t;

  // Saturate a 27-bit signed value to 24 bits.
  function automatic logic [PosW-1:0] sat24(input logic signed [26:0] v);
    logic [PosW-1:0] r;
    if (v > 27'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -27'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/particle_pool_update_core.sv
// Particle pool: slot memory, emit search and per-slot Euler update sequencer.
// Emit: searches slots in order until a free one (up to POOL_SLOTS), then registers the ack.
// Tick: sleeping slots are skipped; an awake slot is read, multiplied, divided by its lifetime,
// given new progress, fade checked and written back, with a second divide in the same shared
// divider when its alpha fades; S_FIN then gives the final result. No result stalls.
// Reset clears awake bits and control/config/result registers; datapath and memory stay undefined.
`default_nettype none
module particle_pool_update_core #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         command_i,
  input  wire  [15:0] dt_i,
  input  wire  [23:0] pos_x_i,
  input  wire  [23:0] pos_y_i,
  input  wire  [23:0] vel_x_i,
  input  wire  [23:0] vel_y_i,
  input  wire  [7:0]  red_i,
  input  wire  [7:0]  green_i,
  input  wire  [7:0]  blue_i,
  input  wire  [7:0]  alpha_in_i,
  input  wire  [15:0] lifetime_i,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_addr_i,
  input  wire  [23:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic        accepted_o,
  output logic [23:0] out_x_o,
  output logic [23:0] out_y_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(POOL_SLOTS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EFIND = 4'd1;
  localparam logic [3:0] S_TRD   = 4'd2;
  localparam logic [3:0] S_TLOAD = 4'd3;
  localparam logic [3:0] S_DIV1  = 4'd4;
  localparam logic [3:0] S_PROG  = 4'd5;
  localparam logic [3:0] S_FADE  = 4'd6;
  localparam logic [3:0] S_DIV2  = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_q;
  logic [IdxW-1:0] idx_q;
  logic [POOL_SLOTS-1:0] awake_q;

  logic [23:0] force_x_q, force_y_q;
  logic [16:0] friction_q;
  logic [15:0] fade_start_q;

  pp_upd_pkg::slot_t mem [POOL_SLOTS];
  pp_upd_pkg::slot_t rdata_q;
  pp_upd_pkg::slot_t emit_q;
  logic [15:0] dt_q;

  logic signed [41:0] prod_px_q, prod_py_q, prod_vx_q, prod_vy_q;
  logic signed [25:0] rnd_px_q, rnd_py_q, rnd_vx_q, rnd_vy_q;
  logic [16:0] prog_q;

  logic [23:0] div_num_q;
  logic [16:0] div_rem_q, div_den_q;
  logic [4:0]  div_cnt_q;

  logic        pend_valid_q;
  logic [23:0] pend_x_q, pend_y_q;
  logic [31:0] pend_color_q;

  logic        res_valid_q, accepted_q, last_q;
  logic [1:0]  kind_q;
  logic [23:0] res_x_q, res_y_q;
  logic [31:0] res_color_q;

  // Products of the Euler step from the slot just read.
  logic signed [24:0] sum_vx, sum_vy;
  logic signed [41:0] mul_px, mul_py, mul_vx, mul_vy;
  assign sum_vx = $signed({rdata_q.vel_x[23], rdata_q.vel_x})
                + $signed({force_x_q[23], force_x_q});
  assign sum_vy = $signed({rdata_q.vel_y[23], rdata_q.vel_y})
                + $signed({force_y_q[23], force_y_q});
  assign mul_px = sum_vx * $signed({1'b0, dt_q});
  assign mul_py = sum_vy * $signed({1'b0, dt_q});
  assign mul_vx = $signed(rdata_q.vel_x) * $signed({1'b0, friction_q});
  assign mul_vy = $signed(rdata_q.vel_y) * $signed({1'b0, friction_q});

  // Divider iteration: restoring, one quotient bit per cycle.
  logic [17:0] div_trial;
  logic        div_ge;
  assign div_trial = {div_rem_q, div_num_q[23]};
  assign div_ge    = div_trial >= {1'b0, div_den_q};

  // Progress update.
  logic [16:0] inc;
  logic [17:0] prog_sum;
  always_comb begin
    if (rdata_q.life == '0) begin
      inc = pp_upd_pkg::PROG_MAX;
    end else if (div_num_q > 24'(pp_upd_pkg::PROG_MAX)) begin
      inc = pp_upd_pkg::PROG_MAX;
    end else begin
      inc = div_num_q[16:0];
    end
    prog_sum = {1'b0, rdata_q.progress} + {1'b0, inc};
  end

  logic        fade, fade_div, still_awake;
  logic [16:0] fade_diff;
  logic [24:0] fade_num;
  assign fade        = prog_q > {1'b0, fade_start_q};
  assign fade_div    = fade && (prog_q < pp_upd_pkg::ONE_Q16);
  assign still_awake = prog_q <= pp_upd_pkg::ONE_Q16;
  assign fade_diff   = pp_upd_pkg::ONE_Q16 - prog_q;
  assign fade_num    = {fade_diff, 8'd0} - {8'd0, fade_diff};

  // Write-back word.
  pp_upd_pkg::slot_t wb;
  logic [7:0] alpha_new;
  always_comb begin
    if (fade_div) begin
      alpha_new = div_num_q[7:0];
    end else if (fade) begin
      alpha_new = 8'd0;
    end else begin
      alpha_new = rdata_q.color[7:0];
    end
    wb.pos_x    = pp_upd_pkg::sat24(27'(signed'(rdata_q.pos_x)) + 27'(rnd_px_q));
    wb.pos_y    = pp_upd_pkg::sat24(27'(signed'(rdata_q.pos_y)) + 27'(rnd_py_q));
    wb.vel_x    = pp_upd_pkg::sat24(27'(rnd_vx_q));
    wb.vel_y    = pp_upd_pkg::sat24(27'(rnd_vy_q));
    wb.color    = {rdata_q.color[31:8], alpha_new};
    wb.life     = rdata_q.life;
    wb.progress = prog_q;
  end

  assign busy = state_q != S_IDLE;

  // Slot memory.
  always_ff @(posedge clk_i) begin
    if (state_q == S_EFIND && !awake_q[idx_q]) begin
      mem[idx_q] <= emit_q;
    end else if (state_q == S_WB) begin
      mem[idx_q] <= wb;
    end
    if (state_q == S_TRD) begin
      rdata_q <= mem[idx_q];
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      dt_q           <= dt_i;
      emit_q.pos_x   <= pos_x_i;
      emit_q.pos_y   <= pos_y_i;
      emit_q.vel_x   <= vel_x_i;
      emit_q.vel_y   <= vel_y_i;
      emit_q.color   <= {red_i, green_i, blue_i, alpha_in_i};
      emit_q.life    <= lifetime_i;
      emit_q.progress <= '0;
    end
    if (state_q == S_TLOAD) begin
      prod_px_q <= mul_px;
      prod_py_q <= mul_py;
      prod_vx_q <= mul_vx;
      prod_vy_q <= mul_vy;
    end
    rnd_px_q <= 26'((prod_px_q + 42'sd32768) >>> 16);
    rnd_py_q <= 26'((prod_py_q + 42'sd32768) >>> 16);
    rnd_vx_q <= 26'((prod_vx_q + 42'sd32768) >>> 16);
    rnd_vy_q <= 26'((prod_vy_q + 42'sd32768) >>> 16);
    if (state_q == S_PROG) begin
      prog_q <= prog_sum[17] ? pp_upd_pkg::PROG_MAX : prog_sum[16:0];
    end
    if (state_q == S_TLOAD) begin
      div_num_q <= {dt_q, 8'd0};
      div_den_q <= {1'b0, rdata_q.life};
      div_rem_q <= '0;
    end else if (state_q == S_FADE) begin
      div_num_q <= fade_num[23:0];
      div_den_q <= pp_upd_pkg::ONE_Q16 - {1'b0, fade_start_q};
      div_rem_q <= '0;
    end else if (state_q == S_DIV1 || state_q == S_DIV2) begin
      div_rem_q <= div_ge ? 17'(div_trial - {1'b0, div_den_q}) : div_trial[16:0];
      div_num_q <= {div_num_q[22:0], div_ge};
    end
    if (state_q == S_WB && still_awake) begin
      pend_x_q     <= wb.pos_x;
      pend_y_q     <= wb.pos_y;
      pend_color_q <= wb.color;
    end
  end

  // Control, configuration and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      awake_q      <= '0;
      div_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      force_x_q    <= '0;
      force_y_q    <= '0;
      friction_q   <= 17'd65536;
      fade_start_q <= 16'd49152;
      res_valid_q  <= 1'b0;
      kind_q       <= pp_upd_pkg::KIND_ACK;
      accepted_q   <= 1'b0;
      last_q       <= 1'b0;
      res_x_q      <= '0;
      res_y_q      <= '0;
      res_color_q  <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          pp_upd_pkg::REG_FORCE_X:    force_x_q    <= cfg_wdata_i;
          pp_upd_pkg::REG_FORCE_Y:    force_y_q    <= cfg_wdata_i;
          pp_upd_pkg::REG_FRICTION:   friction_q   <= cfg_wdata_i[16:0];
          pp_upd_pkg::REG_FADE_START: fade_start_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            idx_q        <= '0;
            pend_valid_q <= 1'b0;
            state_q      <= (command_i == pp_upd_pkg::CMD_EMIT) ? S_EFIND : S_TRD;
          end
        end
        S_EFIND: begin
          if (!awake_q[idx_q] || idx_q == LastIdx) begin
            res_valid_q <= 1'b1;
            kind_q      <= pp_upd_pkg::KIND_ACK;
            accepted_q  <= !awake_q[idx_q];
            last_q      <= 1'b1;
            res_x_q     <= '0;
            res_y_q     <= '0;
            res_color_q <= '0;
            awake_q[idx_q] <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_TRD: begin
          if (awake_q[idx_q]) begin
            state_q <= S_TLOAD;
          end else if (idx_q == LastIdx) begin
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_TLOAD: begin
          div_cnt_q <= '0;
          state_q   <= S_DIV1;
        end
        S_DIV1: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 5'd23) begin
            state_q <= S_PROG;
          end
        end
        S_PROG: begin
          state_q <= S_FADE;
        end
        S_FADE: begin
          div_cnt_q <= '0;
          state_q   <= fade_div ? S_DIV2 : S_WB;
        end
        S_DIV2: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 5'd23) begin
            state_q <= S_WB;
          end
        end
        S_WB: begin
          awake_q[idx_q] <= still_awake;
          // A report goes out only once a later awake slot shows it is not the last.
          if (still_awake) begin
            pend_valid_q <= 1'b1;
            if (pend_valid_q) begin
              res_valid_q <= 1'b1;
              kind_q      <= pp_upd_pkg::KIND_REPORT;
              accepted_q  <= 1'b0;
              last_q      <= 1'b0;
              res_x_q     <= pend_x_q;
              res_y_q     <= pend_y_q;
              res_color_q <= pend_color_q;
            end
          end
          if (idx_q == LastIdx) begin
            state_q <= S_FIN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_TRD;
          end
        end
        S_FIN: begin
          res_valid_q <= 1'b1;
          accepted_q  <= 1'b0;
          last_q      <= 1'b1;
          if (pend_valid_q) begin
            kind_q      <= pp_upd_pkg::KIND_REPORT;
            res_x_q     <= pend_x_q;
            res_y_q     <= pend_y_q;
            res_color_q <= pend_color_q;
          end else begin
            kind_q      <= pp_upd_pkg::KIND_EMPTY;
            res_x_q     <= '0;
            res_y_q     <= '0;
            res_color_q <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign accepted_o     = accepted_q;
  assign out_x_o        = res_x_q;
  assign out_y_o        = res_y_q;
  assign out_red_o      = res_color_q[31:24];
  assign out_green_o    = res_color_q[23:16];
  assign out_blue_o     = res_color_q[15:8];
  assign out_alpha_o    = res_color_q[7:0];
  assign last_o         = last_q;

endmodule
`default_nettype wire
